// ----- rtl/core/lru_pkg.sv -----
package lru_pkg;

  // Operation codes carried in the input beat's tuser.
  typedef enum logic [1:0] {
    OP_LINK   = 2'd0,
    OP_UNLINK = 2'd1,
    OP_MOVE   = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  // Width of the operation code on the input tuser.
  localparam int unsigned OpW = 2;

  // Width of the status flags on the output tuser.
  localparam int unsigned FlagW = 2;

endpackage

// ----- rtl/core/lru_ram.sv -----
module lru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one read port; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lru_order_list.sv -----
// Recency list over SLOTS slots, kept as a doubly linked list in two link
// memories (previous and next) plus a membership memory, with head (most
// recent), tail (least recent) and entry count in registers. Each input beat
// carries an operation in tuser (link at front, unlink, move to front, pop
// tail) and a slot in tdata; each produces exactly one output beat with the
// victim slot, its valid flag, the entry count after the operation and a
// rejected flag. Linking a slot that is already in the list, or unlinking or
// moving one that is not (or a slot index not below SLOTS), is rejected and
// changes nothing. After reset the block clears the membership memory one
// entry per cycle and holds s_axis_tready low until done. One item is worked
// on at a time: a look step reads the slot's links and writes back; a link
// into a non-empty list then points the old head back at the slot, and a
// move of a non-head slot puts it at the front, then points the old head back
// at it. Steps follow from the registered read and single write port of the
// link memories; a move writes the previous-link memory up to three times. A
// finished result can wait in the output register while the next beat is taken.
module lru_order_list #(
  parameter int unsigned SLOTS = 64,
  localparam int unsigned SLOT_W = $clog2(SLOTS),
  localparam int unsigned LINK_W = $clog2(SLOTS + 1),
  localparam int unsigned IN_W   = ((SLOT_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = ((SLOT_W + LINK_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0: slot.
  input  logic [IN_W-1:0]            s_axis_tdata,
  // Fields from bit 0: op.
  input  logic [lru_pkg::OpW-1:0]    s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // Fields from bit 0: victim_slot, entry_count.
  output logic [OUT_W-1:0]           m_axis_tdata,
  // Fields from bit 0: victim_valid, rejected.
  output logic [lru_pkg::FlagW-1:0]  m_axis_tuser
);

  import lru_pkg::*;

  localparam logic [LINK_W-1:0] NONE = LINK_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_WR2,
    ST_WR3,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  logic [SLOT_W-1:0] clr_q, clr_d;
  op_e               op_q, op_d;
  logic [SLOT_W-1:0] s_q, s_d;
  logic              rng_q, rng_d;
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] tail_q, tail_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  logic [LINK_W-1:0] hd_old_q, hd_old_d;

  // Result of the item at work.
  logic [SLOT_W-1:0] rv_slot_q, rv_slot_d;
  logic              rv_valid_q, rv_valid_d;
  logic [LINK_W-1:0] rv_cnt_q, rv_cnt_d;
  logic              rv_rej_q, rv_rej_d;

  // Output register.
  logic              m_valid_q, m_valid_d;
  logic [SLOT_W-1:0] mo_slot_q, mo_slot_d;
  logic              mo_vvalid_q, mo_vvalid_d;
  logic [LINK_W-1:0] mo_cnt_q, mo_cnt_d;
  logic              mo_rej_q, mo_rej_d;

  // Memory ports.
  logic              pw_en, nw_en, mw_en;
  logic [SLOT_W-1:0] pw_addr, nw_addr, mw_addr;
  logic [LINK_W-1:0] pw_data, nw_data;
  logic              mw_data;
  logic [SLOT_W-1:0] rd_addr;
  logic [LINK_W-1:0] p_r, n_r;
  logic              mem_r;

  op_e               in_op;
  logic [SLOT_W-1:0] in_slot;
  logic              in_range;
  logic              p_ex, n_ex, hd_ex, tl_ex;
  logic [LINK_W-1:0] s_link;
  logic              last, out_free, out_ld, accept;

  // Input beat decode and the read address of the item being taken.
  assign in_op    = op_e'(s_axis_tuser);
  assign in_slot  = s_axis_tdata[SLOT_W-1:0];
  assign in_range = LINK_W'(in_slot) < NONE;
  assign rd_addr  = (in_op == OP_POP) ? tail_q[SLOT_W-1:0] : in_slot;
  assign accept   = s_axis_tvalid && (state_q == ST_IDLE);

  assign s_axis_tready = (state_q == ST_IDLE);

  // Link and membership stores.
  lru_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev (
    .clk_i  (clk_i),
    .we_i   (pw_en),
    .waddr_i(pw_addr),
    .wdata_i(pw_data),
    .raddr_i(rd_addr),
    .rdata_o(p_r)
  );

  lru_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next (
    .clk_i  (clk_i),
    .we_i   (nw_en),
    .waddr_i(nw_addr),
    .wdata_i(nw_data),
    .raddr_i(rd_addr),
    .rdata_o(n_r)
  );

  lru_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_member (
    .clk_i  (clk_i),
    .we_i   (mw_en),
    .waddr_i(mw_addr),
    .wdata_i(mw_data),
    .raddr_i(rd_addr),
    .rdata_o(mem_r)
  );

  assign p_ex     = (p_r != NONE);
  assign n_ex     = (n_r != NONE);
  assign hd_ex    = (head_q != NONE);
  assign tl_ex    = (tail_q != NONE);
  assign s_link   = LINK_W'(s_q);
  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer: read the slot's links, then write back the neighbors' links.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    op_d       = op_q;
    s_d        = s_q;
    rng_d      = rng_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    hd_old_d   = hd_old_q;
    rv_slot_d  = rv_slot_q;
    rv_valid_d = rv_valid_q;
    rv_cnt_d   = rv_cnt_q;
    rv_rej_d   = rv_rej_q;
    pw_en      = 1'b0;
    pw_addr    = s_q;
    pw_data    = NONE;
    nw_en      = 1'b0;
    nw_addr    = s_q;
    nw_data    = NONE;
    mw_en      = 1'b0;
    mw_addr    = s_q;
    mw_data    = 1'b0;
    last       = 1'b0;
    out_ld     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mw_en   = 1'b1;
        mw_addr = clr_q;
        mw_data = 1'b0;
        clr_d   = clr_q + SLOT_W'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_d    = in_op;
          s_d     = rd_addr;
          rng_d   = (in_op == OP_POP) || in_range;
          state_d = ST_LOOK;
        end
      end

      ST_LOOK: begin
        rv_slot_d  = '0;
        rv_valid_d = 1'b0;
        rv_rej_d   = 1'b0;
        last       = 1'b1;
        unique case (op_q)
          OP_POP: begin
            if (tl_ex) begin
              rv_slot_d  = s_q;
              rv_valid_d = 1'b1;
              if (p_ex) begin
                nw_en   = 1'b1;
                nw_addr = p_r[SLOT_W-1:0];
                nw_data = NONE;
              end else begin
                head_d = NONE;
              end
              tail_d  = p_r;
              mw_en   = 1'b1;
              mw_data = 1'b0;
              cnt_d   = cnt_q - LINK_W'(1);
            end
          end
          OP_LINK: begin
            if (!rng_q || mem_r) begin
              rv_rej_d = 1'b1;
            end else begin
              mw_en    = 1'b1;
              mw_data  = 1'b1;
              pw_en    = 1'b1;
              pw_data  = NONE;
              nw_en    = 1'b1;
              nw_data  = head_q;
              if (!hd_ex) begin
                tail_d = s_link;
              end
              head_d   = s_link;
              hd_old_d = head_q;
              cnt_d    = cnt_q + LINK_W'(1);
              if (hd_ex) begin
                last    = 1'b0;
                state_d = ST_WR3;
              end
            end
          end
          OP_UNLINK: begin
            if (!rng_q || !mem_r) begin
              rv_rej_d = 1'b1;
            end else begin
              if (p_ex) begin
                nw_en   = 1'b1;
                nw_addr = p_r[SLOT_W-1:0];
                nw_data = n_r;
              end else begin
                head_d = n_r;
              end
              if (n_ex) begin
                pw_en   = 1'b1;
                pw_addr = n_r[SLOT_W-1:0];
                pw_data = p_r;
              end else begin
                tail_d = p_r;
              end
              mw_en   = 1'b1;
              mw_data = 1'b0;
              cnt_d   = cnt_q - LINK_W'(1);
            end
          end
          OP_MOVE: begin
            if (!rng_q || !mem_r) begin
              rv_rej_d = 1'b1;
            end else if (head_q != s_link) begin
              // Not the head, so a previous slot exists.
              nw_en   = 1'b1;
              nw_addr = p_r[SLOT_W-1:0];
              nw_data = n_r;
              if (n_ex) begin
                pw_en   = 1'b1;
                pw_addr = n_r[SLOT_W-1:0];
                pw_data = p_r;
              end else begin
                tail_d = p_r;
              end
              head_d   = s_link;
              hd_old_d = head_q;
              last     = 1'b0;
              state_d  = ST_WR2;
            end
          end
        endcase
        rv_cnt_d = cnt_d;
      end

      ST_WR2: begin
        // Put the slot at the front.
        pw_en   = 1'b1;
        pw_data = NONE;
        nw_en   = 1'b1;
        nw_data = hd_old_q;
        state_d = ST_WR3;
      end

      ST_WR3: begin
        // The old head now points back to the slot.
        pw_en   = 1'b1;
        pw_addr = hd_old_q[SLOT_W-1:0];
        pw_data = s_link;
        last    = 1'b1;
      end

      ST_FIN: begin
        last = 1'b1;
      end
    endcase

    // Hand the result to the output register, or wait until it is free.
    if (last) begin
      if (out_free) begin
        out_ld  = 1'b1;
        state_d = ST_IDLE;
      end else begin
        state_d = ST_FIN;
      end
    end
  end

  // Output register.
  always_comb begin
    m_valid_d   = m_valid_q;
    mo_slot_d   = mo_slot_q;
    mo_vvalid_d = mo_vvalid_q;
    mo_cnt_d    = mo_cnt_q;
    mo_rej_d    = mo_rej_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (out_ld) begin
      m_valid_d   = 1'b1;
      mo_slot_d   = rv_slot_d;
      mo_vvalid_d = rv_valid_d;
      mo_cnt_d    = rv_cnt_d;
      mo_rej_d    = rv_rej_d;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      op_q        <= OP_LINK;
      s_q         <= '0;
      rng_q       <= 1'b0;
      head_q      <= NONE;
      tail_q      <= NONE;
      cnt_q       <= '0;
      hd_old_q    <= NONE;
      rv_slot_q   <= '0;
      rv_valid_q  <= 1'b0;
      rv_cnt_q    <= '0;
      rv_rej_q    <= 1'b0;
      m_valid_q   <= 1'b0;
      mo_slot_q   <= '0;
      mo_vvalid_q <= 1'b0;
      mo_cnt_q    <= '0;
      mo_rej_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      op_q        <= op_d;
      s_q         <= s_d;
      rng_q       <= rng_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      hd_old_q    <= hd_old_d;
      rv_slot_q   <= rv_slot_d;
      rv_valid_q  <= rv_valid_d;
      rv_cnt_q    <= rv_cnt_d;
      rv_rej_q    <= rv_rej_d;
      m_valid_q   <= m_valid_d;
      mo_slot_q   <= mo_slot_d;
      mo_vvalid_q <= mo_vvalid_d;
      mo_cnt_q    <= mo_cnt_d;
      mo_rej_q    <= mo_rej_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({mo_cnt_q, mo_slot_q});
  assign m_axis_tuser  = {mo_rej_q, mo_vvalid_q};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import lru_pkg::*;

  localparam int unsigned NumSlots = 64;
  localparam logic [6:0] NoSlot = 7'd64;
  localparam int unsigned HoldOffCycles = 240;

  // One output beat as the list is expected to report it.
  typedef struct packed {
    logic [5:0] victim_slot;
    logic       victim_valid;
    logic [6:0] entry_count;
    logic       rejected;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid_q = 1'b0;
  logic [7:0]  s_data_q = '0;
  op_e         s_op_q = OP_LINK;
  logic        m_ready_q = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Recency list as the testbench tracks it.
  logic [6:0] link_prev [NumSlots];
  logic [6:0] link_next [NumSlots];
  bit         in_list [NumSlots];
  logic [6:0] head_q = NoSlot;
  logic [6:0] tail_q = NoSlot;
  logic [6:0] count_q = '0;

  list_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  burst_left = 0;
  bit           no_gaps = 1'b0;
  bit           hold_off_req = 1'b0;
  int unsigned  hold_off_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_mode_left = 0;
  int unsigned  stall_phase = 0;

  lru_order_list DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid_q),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data_q),
    .s_axis_tuser  (s_op_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready_q),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Takes a slot out of the list and mends the links of its neighbors.
  function automatic void drop_slot(logic [5:0] s);
    logic [6:0] p;
    logic [6:0] n;
    p = link_prev[s];
    n = link_next[s];
    if (p != NoSlot) link_next[p[5:0]] = n;
    else head_q = n;
    if (n != NoSlot) link_prev[n[5:0]] = p;
    else tail_q = p;
    link_prev[s] = NoSlot;
    link_next[s] = NoSlot;
    in_list[s] = 1'b0;
    if (count_q != 0) count_q = count_q - 1'b1;
  endfunction

  // Puts a slot in front of the current head.
  function automatic void push_front(logic [5:0] s);
    link_prev[s] = NoSlot;
    link_next[s] = head_q;
    if (head_q != NoSlot) link_prev[head_q[5:0]] = {1'b0, s};
    else tail_q = {1'b0, s};
    head_q = {1'b0, s};
    in_list[s] = 1'b1;
    count_q = count_q + 1'b1;
  endfunction

  // Applies one operation to the tracked list and returns the beat it causes.
  function automatic list_result_t apply_list_op(op_e op, logic [5:0] s);
    list_result_t r;
    r = '0;
    case (op)
      OP_LINK: begin
        if (in_list[s]) r.rejected = 1'b1;
        else push_front(s);
      end
      OP_UNLINK: begin
        if (!in_list[s]) r.rejected = 1'b1;
        else drop_slot(s);
      end
      OP_MOVE: begin
        if (!in_list[s]) begin
          r.rejected = 1'b1;
        end else if (head_q != {1'b0, s}) begin
          drop_slot(s);
          push_front(s);
        end
      end
      OP_POP: begin
        if (tail_q != NoSlot) begin
          r.victim_slot = tail_q[5:0];
          r.victim_valid = 1'b1;
          drop_slot(tail_q[5:0]);
        end
      end
      default: r.rejected = 1'b1;
    endcase
    r.entry_count = count_q;
    return r;
  endfunction

  // Picks a random slot that is (or is not) in the list, any slot if none fits.
  function automatic logic [5:0] pick_slot(bit want_member);
    int n;
    int k;
    n = 0;
    for (int i = 0; i < NumSlots; i++) if (in_list[i] == want_member) n++;
    if (n == 0) return 6'($urandom_range(0, NumSlots - 1));
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < NumSlots; i++) begin
      if (in_list[i] == want_member) begin
        if (k == 0) return 6'(i);
        k--;
      end
    end
    return '0;
  endfunction

  // Offers one beat, in bursts with random gaps, and records its result.
  task automatic send_op(op_e op, logic [5:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_valid_q <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid_q <= 1'b1;
    s_op_q <= op;
    s_data_q <= {2'b00, s};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_list_op(op, s));
  endtask

  // Short sequences that hit each special case of the list.
  task automatic test_directed();
    send_op(OP_POP, 6'd17);     // pop on an empty list
    send_op(OP_UNLINK, 6'd0);   // unlink of a slot not in the list
    send_op(OP_MOVE, 6'd63);    // move of a slot not in the list
    send_op(OP_LINK, 6'd0);
    send_op(OP_LINK, 6'd63);
    send_op(OP_LINK, 6'd0);     // link of a slot already in the list
    send_op(OP_MOVE, 6'd63);    // move of the head leaves the order alone
    send_op(OP_MOVE, 6'd0);     // tail to front
    send_op(OP_LINK, 6'd42);
    send_op(OP_LINK, 6'd21);
    send_op(OP_UNLINK, 6'd0);   // from the middle
    send_op(OP_UNLINK, 6'd21);  // the head
    send_op(OP_UNLINK, 6'd63);  // the tail
    send_op(OP_POP, 6'd63);     // last entry
    send_op(OP_POP, 6'd0);
    send_op(OP_LINK, 6'd5);
    send_op(OP_LINK, 6'd6);
    send_op(OP_LINK, 6'd7);
    send_op(OP_MOVE, 6'd6);     // move from the middle
    send_op(OP_POP, 6'd0);
    send_op(OP_POP, 6'd0);
    send_op(OP_POP, 6'd0);
    send_op(OP_UNLINK, 6'd6);
  endtask

  // Fills every slot in random order, works on the full list, then empties it.
  task automatic test_full_list();
    int order [NumSlots];
    int j;
    int t;
    for (int i = 0; i < NumSlots; i++) order[i] = i;
    for (int i = NumSlots - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) send_op(OP_LINK, 6'(order[i]));
    send_op(OP_LINK, pick_slot(1'b1));
    repeat (20) send_op(OP_MOVE, pick_slot(1'b1));
    repeat (10) send_op(OP_UNLINK, pick_slot(1'b1));
    repeat (10) send_op(OP_LINK, pick_slot(1'b0));
    while (count_q != 0) send_op(OP_POP, 6'($urandom_range(0, NumSlots - 1)));
    send_op(OP_POP, 6'($urandom_range(0, NumSlots - 1)));
  endtask

  // Mostly well-formed operations around a drifting list size, some noise.
  task automatic test_random_mix(int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    int unsigned w_link;
    int unsigned w_pop;
    bit          grow;
    target = 8;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 4))
          0: target = 2;
          1: target = 10;
          2: target = 32;
          3: target = 60;
          default: target = 64;
        endcase
      end
      grow = (count_q < target);
      w_link = grow ? 50 : 15;
      w_pop = grow ? 15 : 50;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_op(op_e'($urandom_range(0, 3)), 6'($urandom_range(0, NumSlots - 1)));
      end else begin
        pick = $urandom_range(0, w_link + w_pop + 35 - 1);
        if (pick < w_link || count_q == 0) send_op(OP_LINK, pick_slot(1'b0));
        else if (pick < w_link + w_pop) send_op(OP_POP, 6'($urandom_range(0, NumSlots - 1)));
        else if (pick < w_link + w_pop + 25) send_op(OP_MOVE, pick_slot(1'b1));
        else send_op(OP_UNLINK, pick_slot(1'b1));
      end
    end
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    no_gaps = 1'b1;
    repeat (40) begin
      if (count_q < 40 && $urandom_range(0, 2) != 0) send_op(OP_LINK, pick_slot(1'b0));
      else send_op(OP_MOVE, pick_slot(1'b1));
    end
    no_gaps = 1'b0;
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_off_left = HoldOffCycles;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_ready_q <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(16, 96);
      end
      stall_mode_left--;
      stall_phase++;
      case (stall_mode)
        0: m_ready_q <= 1'b1;
        1: m_ready_q <= 1'($urandom_range(0, 1));
        2: m_ready_q <= ($urandom_range(0, 3) == 0);
        default: m_ready_q <= (stall_phase % 3 != 0);
      endcase
    end
  end

  // Compares each output beat with the oldest pending result.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_ready_q) begin
      if (pending_results.size() == 0) begin
        $error("output beat with no result pending: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[5:0] !== want.victim_slot) begin
          $error("victim_slot expected %0d actual %0d", want.victim_slot, m_axis_tdata[5:0]);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.victim_valid) begin
          $error("victim_valid expected %0d actual %0d", want.victim_valid, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tdata[12:6] !== want.entry_count) begin
          $error("entry_count expected %0d actual %0d", want.entry_count, m_axis_tdata[12:6]);
          error_count++;
        end
        if (m_axis_tuser[1] !== want.rejected) begin
          $error("rejected expected %0d actual %0d", want.rejected, m_axis_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("lru_order_list: mismatch");
    $finish;
  end

  // Reset, the tests in turn, then drain and report.
  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      link_prev[i] = NoSlot;
      link_next[i] = NoSlot;
      in_list[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_list();
    test_random_mix(850);
    test_backpressure();
    test_random_mix(60);
    s_valid_q <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("lru_order_list: match");
    end else begin
      $display("lru_order_list: mismatch");
    end
    $finish;
  end

endmodule
